// File: rtl/core/pit_pkg.sv
// shared types and constants for the polygon point-inside test core
package pit_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int NUM_W        = PROD_W + 1;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] vertex_total;
  } out_item_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic              query_load;
    logic              rd_en;
    logic              first;
    logic [ADDR_W-1:0] rd_addr;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] vcount;
  } stat_t;

endpackage

// File: rtl/core/pit_ram.sv
// generic single write port ram with registered read
module pit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/pit_ctrl.sv
// controller: item decode and edge walk sequencing
module pit_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    kind,
  input  pit_pkg::stat_t stat,
  output logic          busy,
  output pit_pkg::cmd_t cmd
);
  import pit_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] addr_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // first read fetches the last vertex so the closing edge comes out first
  assign addr_sel = (idx == '0) ? (stat.vcount - CNT_W'(1)) : (idx - CNT_W'(1));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (kind)
            KIND_PUSH:  cmd.push  = 1'b1;
            KIND_POP:   cmd.pop   = 1'b1;
            KIND_CLEAR: cmd.clear = 1'b1;
            KIND_QUERY: begin
              cmd.query_load = 1'b1;
              idx_next       = '0;
              state_next     = (stat.vcount == '0) ? ST_FINISH : ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        cmd.rd_en   = 1'b1;
        cmd.first   = (idx == '0);
        cmd.rd_addr = addr_sel[ADDR_W-1:0];
        idx_next    = idx + CNT_W'(1);
        if (idx == stat.vcount) begin
          state_next = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_FINISH;
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> idx <= stat.vcount)
    else $error("walk index past vertex count");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> stat.vcount != '0)
    else $error("edge walk on empty store");

  a_finish_once: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !cmd.finish && state == ST_IDLE)
    else $error("finish not followed by idle");

endmodule

// File: rtl/core/pit_dp.sv
// datapath: vertex store, edge crossing pipeline and result register
module pit_dp (
  input  logic               clk,
  input  logic               rst,
  input  pit_pkg::cmd_t      cmd,
  input  pit_pkg::in_item_t  item,
  output pit_pkg::stat_t     stat,
  output logic               done,
  output pit_pkg::out_item_t result
);
  import pit_pkg::*;

  logic [CNT_W-1:0]        vcount, vcount_next;
  logic                    full;
  logic [2*COORD_BITS-1:0] rdata;

  // query point
  logic signed [COORD_BITS-1:0] px, py;

  // read tag stage
  logic v1, f1;
  logic signed [COORD_BITS-1:0] xa, ya, xb, yb;

  // product stage
  logic v2, hit2, dxneg2;
  logic signed [PROD_W-1:0] pa, pb;
  logic signed [DIFF_W-1:0] dx, dy0, dyb, dxp;
  logic hit1;

  // crossing parities
  logic above_par, below_par;
  logic signed [NUM_W-1:0] num;
  logic num_pos, num_neg, is_above;

  assign full = (vcount >= CNT_W'(MAX_VERTICES));

  always_comb begin
    vcount_next = vcount;
    if (cmd.push && !full) begin
      vcount_next = vcount + CNT_W'(1);
    end else if (cmd.pop && vcount != '0) begin
      vcount_next = vcount - CNT_W'(1);
    end else if (cmd.clear) begin
      vcount_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
    end else begin
      vcount <= vcount_next;
    end
  end

  assign stat.vcount = vcount;

  pit_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (cmd.push && !full),
    .waddr(vcount[ADDR_W-1:0]),
    .wdata({item.x_coord, item.y_coord}),
    .re   (cmd.rd_en),
    .raddr(cmd.rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      px <= item.x_coord;
      py <= item.y_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      f1 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      f1 <= cmd.first;
    end
  end

  assign xb = rdata[2*COORD_BITS-1:COORD_BITS];
  assign yb = rdata[COORD_BITS-1:0];

  // previous vertex follows the read stream
  always_ff @(posedge clk) begin
    if (v1) begin
      xa <= xb;
      ya <= yb;
    end
  end

  assign dx   = DIFF_W'(xb) - DIFF_W'(xa);
  assign dy0  = DIFF_W'(ya) - DIFF_W'(py);
  assign dyb  = DIFF_W'(yb) - DIFF_W'(ya);
  assign dxp  = DIFF_W'(px) - DIFF_W'(xa);
  assign hit1 = (xa < px && xb > px) || (xb < px && xa > px);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1 && !f1;
    end
  end

  always_ff @(posedge clk) begin
    pa     <= PROD_W'(dy0) * PROD_W'(dx);
    pb     <= PROD_W'(dyb) * PROD_W'(dxp);
    hit2   <= hit1;
    dxneg2 <= dx[DIFF_W-1];
  end

  assign num      = NUM_W'(pa) + NUM_W'(pb);
  assign num_neg  = num[NUM_W-1];
  assign num_pos  = !num[NUM_W-1] && (num != '0);
  assign is_above = dxneg2 ? num_neg : num_pos;

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      above_par <= 1'b0;
      below_par <= 1'b0;
    end else if (v2 && hit2) begin
      if (is_above) begin
        above_par <= !above_par;
      end else begin
        below_par <= !below_par;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.push || cmd.pop || cmd.clear || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.inside_res   <= above_par | below_par;
      result.vertex_total <= vcount;
    end else if (cmd.push || cmd.pop || cmd.clear) begin
      result.inside_res   <= 1'b0;
      result.vertex_total <= vcount_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above store depth");

  a_edge_after_read: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1) && !$past(f1))
    else $error("edge stage without matching read");

  a_inside_from_query: assert property (@(posedge clk) disable iff (rst)
    done && result.inside_res |-> $past(cmd.finish))
    else $error("inside flag on non-query item");

endmodule

// File: rtl/core/polygon_point_inside_test_core.sv
// top level of the polygon point-inside test core
// push, pop and clear items: result strobe the cycle after start, one item per cycle
// query item: busy through the edge walk, which reads one vertex per cycle, then two
// drain states and finish, which sets the strobe; an empty store skips the walk
// results cannot be stalled: each strobe lasts one cycle only
// synchronous reset empties the store; vertex contents stay undefined until pushed
module polygon_point_inside_test_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pit_pkg::in_item_t  item,
  output logic               busy,
  output logic               done,
  output pit_pkg::out_item_t result
);
  import pit_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // controller decodes the item kind and sequences the edge walk:
  // one read of the last vertex, then every vertex from the first
  pit_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .kind (item.kind),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  // datapath holds the vertex count, the vertex ram, the two stage
  // crossing test (products, then sum and sign) and the result register
  pit_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .item  (item),
    .stat  (stat),
    .done  (done),
    .result(result)
  );

endmodule

// File: test/polygon_point_inside_test_core_tb.sv
// self-checking testbench for the polygon point-inside test core
`timescale 1ns / 100ps

module polygon_point_inside_test_core_tb;
  import pit_pkg::*;

  // scoreboard: keeps its own copy of the vertex store, works out the answer
  // for every accepted item and matches it against the result strobes
  class crossing_scoreboard;
    int corner_x [MAX_VERTICES];
    int corner_y [MAX_VERTICES];
    int unsigned stored;
    out_item_t awaited [$];
    int unsigned faults;
    int unsigned checked;
    int unsigned queries;
    int unsigned hits;
    int unsigned full_pushes;
    int unsigned empty_pops;

    function new();
      stored = 0;
      faults = 0;
      checked = 0;
      queries = 0;
      hits = 0;
      full_pushes = 0;
      empty_pops = 0;
    endfunction

    // crossing-number rule with the cut cross-multiplied, never divided
    function bit crossing_inside(longint px, longint py);
      bit above;
      bit below;
      int unsigned prev;
      longint xa, ya, xb, yb, lo, hi, dx, num;
      above = 1'b0;
      below = 1'b0;
      for (int unsigned k = 0; k < stored; k++) begin
        prev = (k > 0) ? k - 1 : stored - 1;
        xa = corner_x[prev];
        ya = corner_y[prev];
        xb = corner_x[k];
        yb = corner_y[k];
        lo = (xa < xb) ? xa : xb;
        hi = (xa < xb) ? xb : xa;
        if (lo < px && hi > px) begin
          dx = xb - xa;
          num = (ya - py) * dx + (yb - ya) * (px - xa);
          if (dx < 0) num = -num;
          // a cut exactly at the query y falls to the below side
          if (num > 0) above = ~above;
          else below = ~below;
        end
      end
      if (above ^ below) return 1'b1;
      return above;
    endfunction

    function void note_item(in_item_t it);
      out_item_t want;
      int qx;
      int qy;
      qx = int'($signed(it.x_coord));
      qy = int'($signed(it.y_coord));
      want = '0;
      case (it.kind)
        KIND_PUSH: begin
          if (stored < MAX_VERTICES) begin
            corner_x[stored] = qx;
            corner_y[stored] = qy;
            stored++;
          end else begin
            full_pushes++;
          end
        end
        KIND_POP: begin
          if (stored > 0) stored--;
          else empty_pops++;
        end
        KIND_CLEAR: stored = 0;
        default: begin
          want.inside_res = crossing_inside(qx, qy);
          queries++;
          if (want.inside_res) hits++;
        end
      endcase
      want.vertex_total = stored[CNT_W-1:0];
      awaited.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      faults++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing outstanding", checked));
      end else begin
        want = awaited.pop_front();
        if (got.inside_res !== want.inside_res)
          report_mismatch($sformatf("result %0d inside_res %b, predicted %b",
                                    checked, got.inside_res, want.inside_res));
        if (got.vertex_total !== want.vertex_total)
          report_mismatch($sformatf("result %0d vertex_total %0d, predicted %0d",
                                    checked, got.vertex_total, want.vertex_total));
      end
      checked++;
    endtask

    task leftover_check();
      if (awaited.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", awaited.size()));
    endtask

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  item;
  logic      busy;
  logic      done;
  out_item_t result;

  crossing_scoreboard sb = new();

  // stimulus-side copy of the polygon, used to aim query points and to count items that take effect
  int shape_x [$];
  int shape_y [$];
  int unsigned effective_sent;
  bit burst;

  polygon_point_inside_test_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // monitor: results are taken before the item of the same edge is noted,
  // since no item can produce its result at its own acceptance edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_item(item);
    end
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // present one item and hold it until the block takes it
  task automatic send_item(input kind_t k, input int x, input int y);
    in_item_t nxt;
    int gap;
    gap = burst ? 0 : idle_length();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    nxt.kind = k;
    nxt.x_coord = x[COORD_BITS-1:0];
    nxt.y_coord = y[COORD_BITS-1:0];
    start <= 1'b1;
    item <= nxt;
    do @(posedge clk); while (busy);
    // keep the stimulus copy in step; ignored items do not count
    case (k)
      KIND_PUSH: begin
        if (shape_x.size() < MAX_VERTICES) begin
          shape_x.push_back(int'($signed(x[COORD_BITS-1:0])));
          shape_y.push_back(int'($signed(y[COORD_BITS-1:0])));
          effective_sent++;
        end
      end
      KIND_POP: begin
        if (shape_x.size() > 0) begin
          void'(shape_x.pop_back());
          void'(shape_y.pop_back());
          effective_sent++;
        end
      end
      KIND_CLEAR: begin
        shape_x.delete();
        shape_y.delete();
        effective_sent++;
      end
      default: effective_sent++;
    endcase
  endtask

  // hold the sender off until every outstanding result is back
  task automatic settle_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // query point aimed at the current polygon: inside its box, on a vertex
  // column, on an edge midpoint, on a vertex, or anywhere
  task automatic pick_point(output int px, output int py);
    int n, minx, maxx, miny, maxy, k, j, r;
    n = shape_x.size();
    if (n == 0) begin
      px = any_coord();
      py = any_coord();
      return;
    end
    minx = shape_x[0];
    maxx = shape_x[0];
    miny = shape_y[0];
    maxy = shape_y[0];
    foreach (shape_x[i]) begin
      if (shape_x[i] < minx) minx = shape_x[i];
      if (shape_x[i] > maxx) maxx = shape_x[i];
      if (shape_y[i] < miny) miny = shape_y[i];
      if (shape_y[i] > maxy) maxy = shape_y[i];
    end
    k = $urandom_range(0, n - 1);
    j = (k + 1) % n;
    r = $urandom_range(0, 9);
    px = minx + int'($urandom_range(0, maxx - minx));
    py = miny + int'($urandom_range(0, maxy - miny));
    if (r >= 4 && r < 6) begin
      px = shape_x[k];
    end else if (r >= 6 && r < 8) begin
      // exact midpoint puts the cut right at the query y
      if (((shape_x[k] + shape_x[j]) & 1) == 0 && ((shape_y[k] + shape_y[j]) & 1) == 0) begin
        px = (shape_x[k] + shape_x[j]) >>> 1;
        py = (shape_y[k] + shape_y[j]) >>> 1;
      end
    end else if (r == 8) begin
      px = shape_x[k];
      py = shape_y[k];
    end else if (r == 9) begin
      px = any_coord();
      py = any_coord();
    end
  endtask

  // well-formed run: clear, build a polygon, query it, sometimes trim and requery
  task automatic polygon_sequence();
    int nv, nq, span, cx, cy, px, py;
    bit wide;
    wide = ($urandom_range(0, 4) == 0);
    nv = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
    span = $urandom_range(4, 200);
    cx = int'($urandom_range(0, 60000)) - 30000;
    cy = int'($urandom_range(0, 60000)) - 30000;
    send_item(KIND_CLEAR, any_coord(), any_coord());
    for (int i = 0; i < nv; i++) begin
      if (wide) send_item(KIND_PUSH, any_coord(), any_coord());
      else send_item(KIND_PUSH, cx + int'($urandom_range(0, 2 * span)) - span,
                     cy + int'($urandom_range(0, 2 * span)) - span);
    end
    nq = $urandom_range(2, 8);
    for (int i = 0; i < nq; i++) begin
      pick_point(px, py);
      send_item(KIND_QUERY, px, py);
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) send_item(KIND_POP, any_coord(), any_coord());
      repeat (2) begin
        pick_point(px, py);
        send_item(KIND_QUERY, px, py);
      end
    end
  endtask

  // noise: any kind, any coordinates
  task automatic noise_sequence();
    repeat ($urandom_range(1, 8))
      send_item(kind_t'($urandom_range(0, 3)), any_coord(), any_coord());
  endtask

  initial begin
    int unsigned base;
    int r;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    effective_sent = 0;
    burst = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, extreme corners, vertical edges, cuts on the point
    send_item(KIND_QUERY, 0, 0);              // no vertices
    send_item(KIND_POP, 0, 0);                // pop on an empty store
    send_item(KIND_PUSH, -32768, -32768);
    send_item(KIND_QUERY, -32768, -32768);    // single vertex
    send_item(KIND_PUSH, 32767, 32767);
    send_item(KIND_QUERY, 0, 0);              // two vertices, degenerate
    send_item(KIND_PUSH, 32767, -32768);
    send_item(KIND_QUERY, 16384, -100);
    send_item(KIND_QUERY, 32767, 0);          // query x on a vertex column
    send_item(KIND_QUERY, 0, 0);              // exactly on the diagonal
    send_item(KIND_QUERY, -32768, 32767);
    send_item(KIND_CLEAR, 32767, -1);
    send_item(KIND_PUSH, 0, 0);               // square with vertical sides
    send_item(KIND_PUSH, 0, 10);
    send_item(KIND_PUSH, 10, 10);
    send_item(KIND_PUSH, 10, 0);
    send_item(KIND_QUERY, 5, 5);
    send_item(KIND_QUERY, 0, 5);              // on a vertical edge
    send_item(KIND_QUERY, 5, 10);             // cut level with the point
    send_item(KIND_QUERY, 5, -3);
    send_item(KIND_POP, -1, -1);
    send_item(KIND_QUERY, 7, 2);              // remaining triangle
    send_item(KIND_CLEAR, 0, 0);
    settle_results();

    // random: mostly well-formed polygons, some noise, some full settles
    base = effective_sent;
    while (effective_sent - base < 555) begin
      burst = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) polygon_sequence();
      else if (r < 95) noise_sequence();
      else settle_results();
    end
    burst = 1'b0;
    settle_results();

    // drain, then idle cycles to catch stray strobes
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.leftover_check();

    $display("run summary: %0d results checked, %0d point queries (%0d inside)",
             sb.checked, sb.queries, sb.hits);
    $display("store limits hit: %0d pushes on a full store, %0d pops on an empty one",
             sb.full_pushes, sb.empty_pops);
    if (sb.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pit_pkg.sv
rtl/core/pit_ram.sv
rtl/core/pit_ctrl.sv
rtl/core/pit_dp.sv
rtl/core/polygon_point_inside_test_core.sv
test/polygon_point_inside_test_core_tb.sv
